// ===== src/spcq_pkg.sv =====
// ----------------------------------------------------------------------------
// spcq_pkg: shared types and constants
// widths and pipeline record types for the sphere point collision query
// ----------------------------------------------------------------------------
`default_nettype none

package spcq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int RAD_W     = 31;
   localparam int CTR_W     = 33;    // base + offset, no wrap
   localparam int DELTA_W   = 34;
   localparam int MAG_W     = 33;
   localparam int SQ_W      = 66;
   localparam int D2_W      = 68;
   localparam int PROD_W    = 64;
   localparam int NRM_W     = 18;

   localparam int ROOT_W    = 36;    // one root bit per sqrt cell
   localparam int RADIC_W   = 2 * ROOT_W;
   localparam int SREM_W    = ROOT_W + 2;

   localparam int DIV_Q_W   = 31;    // one quotient bit per divide cell
   localparam int DIV_N_W   = 62;
   localparam int DIV_D_W   = ROOT_W;
   localparam int DIV_R_W   = DIV_D_W + 1;
   localparam int LANES     = 6;     // three normal lanes, three surface lanes

   localparam logic [2:0] REG_BASE_X   = 3'd0;
   localparam logic [2:0] REG_BASE_Y   = 3'd1;
   localparam logic [2:0] REG_BASE_Z   = 3'd2;
   localparam logic [2:0] REG_OFFSET_X = 3'd3;
   localparam logic [2:0] REG_OFFSET_Y = 3'd4;
   localparam logic [2:0] REG_OFFSET_Z = 3'd5;
   localparam logic [2:0] REG_RADIUS   = 3'd6;

   typedef struct packed {
      logic [2:0][CTR_W-1:0]  centre;
      logic [2:0]             neg;
      logic                   in_sphere;
      logic                   degen;
   } geo_type;

   typedef struct packed {
      logic                   valid;
      geo_type                geo;
      logic [2:0][MAG_W-1:0]  mag;
      logic [2:0][PROD_W-1:0] prod;
      logic [RADIC_W-1:0]     radic;
      logic [SREM_W-1:0]      rem;
      logic [ROOT_W-1:0]      root;
   } sq_type;

   typedef struct packed {
      logic                         valid;
      geo_type                      geo;
      logic [DIV_D_W-1:0]           len;
      logic [LANES-1:0][DIV_R_W-1:0] rem;
      logic [LANES-1:0][DIV_N_W-1:0] num;
      logic [LANES-1:0][DIV_Q_W-1:0] quot;
   } dv_type;

endpackage

`default_nettype wire

// ===== src/spcq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// spcq_sqrt_cell: one digit of the square root chain
// takes two radicand bits and settles one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module spcq_sqrt_cell
   import spcq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire sq_type d,
   output sq_type      q
);

   sq_type             q_ff;
   sq_type             q_in;
   logic [SREM_W-1:0]  rem_sh;
   logic [SREM_W-1:0]  trial;

   always_comb begin
      q_in   = d;
      rem_sh = {d.rem[SREM_W-3:0], d.radic[RADIC_W-1 -: 2]};
      trial  = {d.root[ROOT_W-3:0], 2'b01};
      q_in.radic = {d.radic[RADIC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         q_in.rem  = rem_sh - trial;
         q_in.root = {d.root[ROOT_W-2:0], 1'b1};
      end else begin
         q_in.rem  = rem_sh;
         q_in.root = {d.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= q_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff.geo   <= q_in.geo;
         q_ff.mag   <= q_in.mag;
         q_ff.prod  <= q_in.prod;
         q_ff.radic <= q_in.radic;
         q_ff.rem   <= q_in.rem;
         q_ff.root  <= q_in.root;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ===== src/spcq_div_cell.sv =====
// ----------------------------------------------------------------------------
// spcq_div_cell: one quotient bit of the divide chain
// restoring step on all six lanes against the shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module spcq_div_cell
   import spcq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire dv_type d,
   output dv_type      q
);

   dv_type              q_ff;
   dv_type              q_in;
   logic [DIV_R_W-1:0]  sh;

   always_comb begin
      q_in = d;
      sh   = '0;
      for (int i = 0; i < LANES; i++) begin
         sh = {d.rem[i][DIV_R_W-2:0], d.num[i][DIV_N_W-1]};
         q_in.num[i] = {d.num[i][DIV_N_W-2:0], 1'b0};
         if (sh >= {1'b0, d.len}) begin
            q_in.rem[i]  = sh - {1'b0, d.len};
            q_in.quot[i] = {d.quot[i][DIV_Q_W-2:0], 1'b1};
         end else begin
            q_in.rem[i]  = sh;
            q_in.quot[i] = {d.quot[i][DIV_Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff.valid <= q_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff.geo  <= q_in.geo;
         q_ff.len  <= q_in.len;
         q_ff.rem  <= q_in.rem;
         q_ff.num  <= q_in.num;
         q_ff.quot <= q_in.quot;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

// ===== src/sphere_point_collision_query.sv =====
// ----------------------------------------------------------------------------
// sphere_point_collision_query: point against sphere test and projection
// gives inside flag, surface projection and unit normal for each point
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  point x, y, z (Q16.16)
//  rsp       out        rsp_valid/rsp_stall  inside, surface xyz, normal xyz, degenerate
//  csr       in         apb psel/penable     base, offset, radius registers
//
//  one transaction per cycle while the chain is not held; 5 front stages,
//  36 sqrt cells, 31 divide cells, one output register
//  synchronous active-high reset clears all valid bits and the registers
//  the whole chain advances together; it holds only while a result sits
//  in the output register and rsp_stall is high
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_point_collision_query
   import spcq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COORD_W-1:0]  req_point_x,
   input  wire logic [COORD_W-1:0]  req_point_y,
   input  wire logic [COORD_W-1:0]  req_point_z,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_inside_res,
   output logic [COORD_W-1:0]       rsp_surface_x,
   output logic [COORD_W-1:0]       rsp_surface_y,
   output logic [COORD_W-1:0]       rsp_surface_z,
   output logic [NRM_W-1:0]         rsp_normal_x,
   output logic [NRM_W-1:0]         rsp_normal_y,
   output logic [NRM_W-1:0]         rsp_normal_z,
   output logic                     rsp_degenerate,
   // configuration port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [2:0][COORD_W-1:0] base_ff;
   logic [2:0][COORD_W-1:0] off_ff;
   logic [RAD_W-1:0]        radius_ff;
   logic [2*RAD_W-1:0]      r2_ff;       // radius squared, kept beside the register
   logic [2:0][CTR_W-1:0]   ctr_ff;      // centre, kept beside the registers
   logic                    wr_en;
   logic [2:0]              reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         off_ff    <= '0;
         radius_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BASE_X:   base_ff[0] <= pwdata;
            REG_BASE_Y:   base_ff[1] <= pwdata;
            REG_BASE_Z:   base_ff[2] <= pwdata;
            REG_OFFSET_X: off_ff[0]  <= pwdata;
            REG_OFFSET_Y: off_ff[1]  <= pwdata;
            REG_OFFSET_Z: off_ff[2]  <= pwdata;
            REG_RADIUS:   radius_ff  <= pwdata[RAD_W-1:0];
            default: ;  // unused address, write dropped
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BASE_X:   prdata = base_ff[0];
         REG_BASE_Y:   prdata = base_ff[1];
         REG_BASE_Z:   prdata = base_ff[2];
         REG_OFFSET_X: prdata = off_ff[0];
         REG_OFFSET_Y: prdata = off_ff[1];
         REG_OFFSET_Z: prdata = off_ff[2];
         REG_RADIUS:   prdata = {1'b0, radius_ff};
         default:      prdata = '0;
      endcase
   end

   // derived values follow the registers in the next cycle; the user must write config
   // only while idle (the block does not enforce it) so the pipeline always sees settled values
   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
      for (int i = 0; i < 3; i++) begin
         ctr_ff[i] <= {base_ff[i][COORD_W-1], base_ff[i]}
                    + {off_ff[i][COORD_W-1], off_ff[i]};
      end
   end

   // ------------------------------------------------------------------
   // global advance: the chain moves unless the output is held
   // ------------------------------------------------------------------
   logic en;
   logic out_valid_ff;

   assign en        = !(out_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ------------------------------------------------------------------
   // front stages
   // ------------------------------------------------------------------
   logic                      p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [2:0][COORD_W-1:0]   p1_pt_ff;
   logic [2:0][DELTA_W-1:0]   p2_delta_ff;
   logic [2:0][CTR_W-1:0]     p2_ctr_ff, p3_ctr_ff, p4_ctr_ff;
   logic [2:0]                p3_neg_ff, p4_neg_ff;
   logic [2:0][MAG_W-1:0]     p3_mag_ff, p4_mag_ff;
   logic [2:0][SQ_W-1:0]      p4_sq_ff;
   logic [2:0][PROD_W-1:0]    p4_prod_ff;
   logic [D2_W-1:0]           d2_sum;
   sq_type                    sq_chain [ROOT_W+1];
   sq_type                    sq_head_ff;

   function automatic logic [MAG_W-1:0] mag_of(input logic [DELTA_W-1:0] dv);
      logic [DELTA_W-1:0] a;
      a = dv[DELTA_W-1] ? (~dv + 1'b1) : dv;
      return a[MAG_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff       <= 1'b0;
         p2_valid_ff       <= 1'b0;
         p3_valid_ff       <= 1'b0;
         p4_valid_ff       <= 1'b0;
         sq_head_ff.valid  <= 1'b0;
      end else if (en) begin
         p1_valid_ff       <= req_valid;
         p2_valid_ff       <= p1_valid_ff;
         p3_valid_ff       <= p2_valid_ff;
         p4_valid_ff       <= p3_valid_ff;
         sq_head_ff.valid  <= p4_valid_ff;
      end
   end

   always_comb begin
      d2_sum = '0;
      for (int i = 0; i < 3; i++) begin
         d2_sum = d2_sum + {{(D2_W-SQ_W){1'b0}}, p4_sq_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: capture point
         p1_pt_ff[0] <= req_point_x;
         p1_pt_ff[1] <= req_point_y;
         p1_pt_ff[2] <= req_point_z;
         for (int i = 0; i < 3; i++) begin
            // stage 2: vector from point to centre
            p2_delta_ff[i] <= {ctr_ff[i][CTR_W-1], ctr_ff[i]}
                            - {{(DELTA_W-COORD_W){p1_pt_ff[i][COORD_W-1]}}, p1_pt_ff[i]};
            p2_ctr_ff[i]   <= ctr_ff[i];
            // stage 3: magnitude and sign
            p3_neg_ff[i]   <= p2_delta_ff[i][DELTA_W-1];
            p3_ctr_ff[i]   <= p2_ctr_ff[i];
            // stage 4: squares and radius products
            p4_sq_ff[i]    <= p3_mag_ff[i] * p3_mag_ff[i];
            p4_prod_ff[i]  <= p3_mag_ff[i] * radius_ff;
            p4_mag_ff[i]   <= p3_mag_ff[i];
            p4_neg_ff[i]   <= p3_neg_ff[i];
            p4_ctr_ff[i]   <= p3_ctr_ff[i];
         end
         p3_mag_ff[0] <= mag_of(p2_delta_ff[0]);
         p3_mag_ff[1] <= mag_of(p2_delta_ff[1]);
         p3_mag_ff[2] <= mag_of(p2_delta_ff[2]);
         // stage 5: squared distance, flags, sqrt seed
         sq_head_ff.geo.centre    <= p4_ctr_ff;
         sq_head_ff.geo.neg       <= p4_neg_ff;
         sq_head_ff.geo.in_sphere <= d2_sum < {{(D2_W-2*RAD_W){1'b0}}, r2_ff};
         sq_head_ff.geo.degen     <= d2_sum == '0;
         sq_head_ff.mag           <= p4_mag_ff;
         sq_head_ff.prod          <= p4_prod_ff;
         sq_head_ff.radic         <= {{(RADIC_W-D2_W){1'b0}}, d2_sum};
         sq_head_ff.rem           <= '0;
         sq_head_ff.root          <= '0;
      end
   end

   // ------------------------------------------------------------------
   // square root chain: one root bit per cell
   // ------------------------------------------------------------------
   assign sq_chain[0] = sq_head_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      spcq_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (sq_chain[k]),
         .q     (sq_chain[k+1])
      );
   end

   // ------------------------------------------------------------------
   // divide chain: normal lanes divide mag<<FRAC_BITS, surface lanes
   // divide mag*radius, both by the distance
   // ------------------------------------------------------------------
   dv_type               dv_chain [DIV_Q_W+1];
   dv_type               dv_head;
   logic [DIV_N_W-1:0]   nval;
   sq_type               sq_tail;

   assign sq_tail = sq_chain[ROOT_W];

   always_comb begin
      dv_head       = '0;
      nval          = '0;
      dv_head.valid = sq_tail.valid;
      dv_head.geo   = sq_tail.geo;
      dv_head.len   = sq_tail.root;
      for (int i = 0; i < LANES; i++) begin
         if (i < 3) begin
            nval = {{(DIV_N_W-MAG_W-FRAC_BITS){1'b0}}, sq_tail.mag[i % 3],
                    {FRAC_BITS{1'b0}}};
         end else begin
            nval = sq_tail.prod[i % 3][DIV_N_W-1:0];
         end
         dv_head.rem[i]  = {{(DIV_R_W-DIV_Q_W){1'b0}}, nval[DIV_N_W-1 -: DIV_Q_W]};
         dv_head.num[i]  = {nval[DIV_N_W-DIV_Q_W-1:0], {DIV_Q_W{1'b0}}};
         dv_head.quot[i] = '0;
      end
   end

   assign dv_chain[0] = dv_head;

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_div
      spcq_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (dv_chain[k]),
         .q     (dv_chain[k+1])
      );
   end

   // ------------------------------------------------------------------
   // output register: sign, saturation and forcing
   // ------------------------------------------------------------------
   localparam logic [DIV_Q_W-1:0] NRM_ONE  = DIV_Q_W'(1) << FRAC_BITS;
   localparam int                 SUM_W    = CTR_W + 2;
   localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(64'sh7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] S_MIN = -SUM_W'(64'sh8000_0000);

   dv_type                    dv_tail;
   logic [2:0][COORD_W-1:0]   surf_in;
   logic [2:0][NRM_W-1:0]     nrm_in;
   logic [2:0][COORD_W-1:0]   surf_ff;
   logic [2:0][NRM_W-1:0]     nrm_ff;
   logic                      inside_ff;
   logic                      degen_ff;
   logic [DIV_Q_W-1:0]        nq;
   logic [NRM_W-1:0]          nmag;
   logic signed [SUM_W-1:0]   ctr_x;
   logic signed [SUM_W-1:0]   sc_x;
   logic signed [SUM_W-1:0]   s_val;

   assign dv_tail = dv_chain[DIV_Q_W];

   always_comb begin
      nq    = '0;
      nmag  = '0;
      ctr_x = '0;
      sc_x  = '0;
      s_val = '0;
      for (int i = 0; i < 3; i++) begin
         nq   = dv_tail.quot[i];
         nmag = (nq > NRM_ONE) ? NRM_ONE[NRM_W-1:0] : nq[NRM_W-1:0];
         if (dv_tail.geo.degen) begin
            nrm_in[i] = '0;
         end else begin
            nrm_in[i] = dv_tail.geo.neg[i] ? (~nmag + 1'b1) : nmag;
         end
         ctr_x = {{(SUM_W-CTR_W){dv_tail.geo.centre[i][CTR_W-1]}}, dv_tail.geo.centre[i]};
         sc_x  = {{(SUM_W-DIV_Q_W){1'b0}}, dv_tail.quot[i+3]};
         s_val = dv_tail.geo.neg[i] ? (ctr_x + sc_x) : (ctr_x - sc_x);
         if (!dv_tail.geo.in_sphere || dv_tail.geo.degen) begin
            surf_in[i] = '0;
         end else if (s_val > S_MAX) begin
            surf_in[i] = S_MAX[COORD_W-1:0];
         end else if (s_val < S_MIN) begin
            surf_in[i] = S_MIN[COORD_W-1:0];
         end else begin
            surf_in[i] = s_val[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         surf_ff   <= surf_in;
         nrm_ff    <= nrm_in;
         inside_ff <= dv_tail.geo.in_sphere;
         degen_ff  <= dv_tail.geo.degen;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_surface_x  = surf_ff[0];
   assign rsp_surface_y  = surf_ff[1];
   assign rsp_surface_z  = surf_ff[2];
   assign rsp_normal_x   = nrm_ff[0];
   assign rsp_normal_y   = nrm_ff[1];
   assign rsp_normal_z   = nrm_ff[2];
   assign rsp_degenerate = degen_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 &&
         rsp_surface_x == '0 && rsp_surface_y == '0 && rsp_surface_z == '0)
      else $error("degenerate result with nonzero vectors");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |->
         rsp_surface_x == '0 && rsp_surface_y == '0 && rsp_surface_z == '0)
      else $error("surface point given for outside point");

   a_nrm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_normal_x) <= 18'sd65536 &&
                    $signed(rsp_normal_x) >= -18'sd65536)
      else $error("normal x out of unit range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
